// ----- hw/rtl/sxd_pkg.sv -----
// shared types and constants for the sync/length/xor packet deframer
package sxd_pkg;

  // byte and register widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 32;

  // register reset values
  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] SIZE_RESET = 8'h06;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SYNC_VALUE    = 1'b0,
    CFG_EXPECTED_SIZE = 1'b1
  } cfg_idx_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SIZE  = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_CHECK = 2'd2
  } status_t;

  // one result request
  typedef struct packed {
    status_t                     status;
    logic signed [VALUE_W-1:0]   value;
    logic        [BYTE_W-1:0]    received_check;
  } result_t;

  // handshake between parser and result register
  typedef struct packed {
    logic    load;   // parser hands a result to the output register
    result_t res;
  } out_load_t;

endpackage

// ----- hw/rtl/sxd_in_stage.sv -----
// input register for received bytes
module sxd_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sxd_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                          consume,
  output logic                          item_valid,
  output logic [sxd_pkg::BYTE_W-1:0]    item_byte
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [sxd_pkg::BYTE_W-1:0]    byte_r;
  logic                          accept;

  // hold a request until the parser consumes it
  assign in_stall   = valid_r && !consume;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // byte payload
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ----- hw/rtl/sxd_parse.sv -----
// packet framing state machine with xor and data accumulation
module sxd_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  logic [sxd_pkg::BYTE_W-1:0]    item_byte,
  input  logic [sxd_pkg::BYTE_W-1:0]    sync_value,
  input  logic [sxd_pkg::BYTE_W-1:0]    expected_size,
  input  logic                          out_free,
  output logic                          consume,
  output sxd_pkg::out_load_t            out_load
);

  sxd_pkg::phase_t                     phase_r;
  sxd_pkg::phase_t                     phase_nxt;
  logic [1:0]                          count_r;
  logic [1:0]                          count_nxt;
  logic [sxd_pkg::BYTE_W-1:0]          xor_r;
  logic [sxd_pkg::BYTE_W-1:0]          xor_nxt;
  logic [sxd_pkg::VALUE_W-1:0]         shift_r;
  logic [sxd_pkg::VALUE_W-1:0]         shift_nxt;
  logic                                has_result;
  sxd_pkg::result_t                    res;

  // next state and result for the byte at the head of the input register
  always_comb begin
    phase_nxt          = phase_r;
    count_nxt          = count_r;
    xor_nxt            = xor_r;
    shift_nxt          = shift_r;
    has_result         = 1'b0;
    res.status         = sxd_pkg::ST_OK;
    res.value          = '0;
    res.received_check = '0;
    case (phase_r)
      sxd_pkg::PH_HUNT: begin
        if (item_byte == sync_value) begin
          phase_nxt = sxd_pkg::PH_SIZE;
          count_nxt = 2'd0;
          xor_nxt   = '0;
          shift_nxt = '0;
        end
      end
      sxd_pkg::PH_SIZE: begin
        if (item_byte != expected_size) begin
          // size mismatch: report and hunt again
          has_result = 1'b1;
          res.status = sxd_pkg::ST_SIZE;
          phase_nxt  = sxd_pkg::PH_HUNT;
          count_nxt  = 2'd0;
          xor_nxt    = '0;
          shift_nxt  = '0;
        end else begin
          phase_nxt = sxd_pkg::PH_DATA;
          count_nxt = 2'd0;
        end
      end
      sxd_pkg::PH_DATA: begin
        shift_nxt = {shift_r[sxd_pkg::VALUE_W-sxd_pkg::BYTE_W-1:0], item_byte};
        xor_nxt   = xor_r ^ item_byte;
        if (count_r == 2'd3) begin
          phase_nxt = sxd_pkg::PH_CHECK;
          count_nxt = 2'd0;
        end else begin
          count_nxt = count_r + 2'd1;
        end
      end
      sxd_pkg::PH_CHECK: begin
        has_result         = 1'b1;
        res.status         = (item_byte == xor_r) ? sxd_pkg::ST_OK : sxd_pkg::ST_CHECK;
        res.value          = shift_r;
        res.received_check = item_byte;
        phase_nxt          = sxd_pkg::PH_HUNT;
        count_nxt          = 2'd0;
        xor_nxt            = '0;
        shift_nxt          = '0;
      end
      default: begin
        phase_nxt = sxd_pkg::PH_HUNT;
      end
    endcase
  end

  // a byte with a result waits for room in the output register
  assign consume       = item_valid && (!has_result || out_free);
  assign out_load.load = consume && has_result;
  assign out_load.res  = res;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sxd_pkg::PH_HUNT;
      count_r <= 2'd0;
      xor_r   <= '0;
      shift_r <= '0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// ----- hw/rtl/sxd_out_stage.sv -----
// output register holding one result request
module sxd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sxd_pkg::out_load_t   out_load,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sxd_pkg::result_t     out_res
);

  logic              valid_r;
  logic              valid_nxt;
  sxd_pkg::result_t  res_r;

  // free when empty or being taken this cycle
  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_load.load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load.load) begin
      res_r <= out_load.res;
    end
  end

endmodule

// ----- hw/rtl/sync_length_xor_packet_deframer.sv -----
// top level of the sync/length/xor packet deframer
//
//   channel  ports                                   direction
//   in       in_valid in_stall in_rx_byte            byte requests in
//   out      out_valid out_stall out_status
//            out_value out_received_check            result requests out
//   cfg      cfg_we cfg_index cfg_wdata              register writes in
//
// one byte per cycle unless a result is held by out_stall; a byte is parsed in the
// cycle after it is taken and its result, if any, shows on the out port the cycle after that.
// the framing state machine between the input and output registers sets the rate.
// reset is synchronous, active low; it empties both registers and clears the parser.
// a stalled result holds; bytes that cause no result keep flowing past it,
// and a byte that would cause a result waits in the input register.
module sync_length_xor_packet_deframer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sxd_pkg::BYTE_W-1:0]           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic signed [sxd_pkg::VALUE_W-1:0]   out_value,
  output logic [sxd_pkg::BYTE_W-1:0]           out_received_check,
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_index,
  input  logic [sxd_pkg::BYTE_W-1:0]           cfg_wdata
);

  logic [sxd_pkg::BYTE_W-1:0]  sync_value_r;
  logic [sxd_pkg::BYTE_W-1:0]  expected_size_r;
  logic                        item_valid;
  logic [sxd_pkg::BYTE_W-1:0]  item_byte;
  logic                        consume;
  logic                        out_free;
  sxd_pkg::out_load_t          out_load;
  sxd_pkg::result_t            out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r    <= sxd_pkg::SYNC_RESET;
      expected_size_r <= sxd_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sxd_pkg::CFG_SYNC_VALUE) begin
        sync_value_r <= cfg_wdata;
      end
      if (cfg_index == sxd_pkg::CFG_EXPECTED_SIZE) begin
        expected_size_r <= cfg_wdata;
      end
    end
  end

  // input register
  sxd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .consume    (consume),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  // framing logic
  sxd_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_byte     (item_byte),
    .sync_value    (sync_value_r),
    .expected_size (expected_size_r),
    .out_free      (out_free),
    .consume       (consume),
    .out_load      (out_load)
  );

  // result register
  sxd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_load  (out_load),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // result fields
  assign out_status         = out_res.status;
  assign out_value          = out_res.value;
  assign out_received_check = out_res.received_check;

endmodule
